@@ design/block_bitmap_allocator_core_assert.svh @@
// Assertion macros shared by the block bitmap allocator modules.
// Needs signals named clk and rst_n in the module that uses them.
`ifndef BLOCK_BITMAP_ALLOCATOR_CORE_ASSERT_SVH
`define BLOCK_BITMAP_ALLOCATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define BBA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bba: same-cycle check failed");
// Next-cycle implication.
`define BBA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bba: next-cycle check failed");
`else
`define BBA_ASSERT_IMP(lbl, ante, cons)
`define BBA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ design/bba_pkg.sv @@
// Shared types and constants of the block bitmap allocator.
// No dependencies; the controller, datapath and top modules import it.
package bba_pkg;

  localparam int MAX_BLOCKS_DEF = 4096;
  localparam int BYTE_BITS      = 8;
  localparam int CNT_W          = 13;
  localparam int IDX_W          = 12;
  localparam int MODE_W         = 3;
  localparam int STAT_W         = 2;
  localparam int POS_W          = CNT_W - 3;
  localparam int TOT_W          = POS_W + 1;

  localparam logic [CNT_W-1:0] BLOCK_COUNT_RST = CNT_W'(4096);
  localparam logic [7:0]       BYTE_FULL       = 8'hFF;

  typedef enum logic [MODE_W-1:0] {
    MODE_QUERY     = 3'd0,
    MODE_MARK_USED = 3'd1,
    MODE_MARK_FREE = 3'd2,
    MODE_FIND      = 3'd3,
    MODE_CLEAR     = 3'd4
  } mode_t;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EXHAUSTED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE     = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  block_index;
  } in_item_t;

  typedef struct packed {
    logic              block_used;
    logic [IDX_W-1:0]  found_block;
    logic [STAT_W-1:0] status;
  } out_item_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_ACCESS,
    S_CLEAR,
    S_MOD,
    S_SCAN,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic take;
    logic access;
    logic clr_run;
    logic mod_run;
    logic scan_run;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic dec_access;
    logic dec_clear;
    logic dec_find;
    logic map_none;
    logic need_mod;
    logic clr_last;
    logic mod_last;
    logic scan_hit;
    logic scan_miss;
    logic out_free;
  } sts_t;

endpackage

@@ design/bba_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module bba_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 512,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/bba_ctrl.sv @@
// Controller state machine of the block bitmap allocator.
// Depends on bba_pkg and the shared assertion macros.
`include "block_bitmap_allocator_core_assert.svh"

module bba_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output bba_pkg::cmd_t cmd,
  input  bba_pkg::sts_t sts
);
  import bba_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (sts.dec_access) begin
            state_nxt = S_ACCESS;
          end else if (sts.dec_clear) begin
            state_nxt = S_CLEAR;
          end else if (sts.dec_find && !sts.map_none) begin
            state_nxt = sts.need_mod ? S_MOD : S_SCAN;
          end else begin
            state_nxt = S_RESULT;
          end
        end
      end
      S_ACCESS: state_nxt = S_RESULT;
      S_CLEAR: begin
        if (sts.clr_last) state_nxt = S_RESULT;
      end
      S_MOD: begin
        if (sts.mod_last) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_hit || sts.scan_miss) state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_INIT:   cmd.clr_run = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      S_ACCESS: cmd.access   = 1'b1;
      S_CLEAR:  cmd.clr_run  = 1'b1;
      S_MOD:    cmd.mod_run  = 1'b1;
      S_SCAN:   cmd.scan_run = 1'b1;
      S_RESULT: cmd.emit     = sts.out_free;
      default:  cmd          = '0;
    endcase
  end

  `BBA_ASSERT_NXT(a_access_one_cycle, state_r == S_ACCESS, state_r == S_RESULT)
  `BBA_ASSERT_NXT(a_take_leaves_idle, cmd.take, state_r != S_IDLE)
  `BBA_ASSERT_IMP(a_ready_only_idle, in_ready, state_r == S_IDLE)

endmodule

@@ design/bba_dpath.sv @@
// Datapath of the block bitmap allocator: map RAM, hint, ring modulo, scan and output register.
// Depends on bba_pkg, bba_ram and the shared assertion macros.
`include "block_bitmap_allocator_core_assert.svh"

module bba_dpath #(
  parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  input  logic [bba_pkg::CNT_W-1:0]   cfg_data,
  input  bba_pkg::in_item_t           in_data,
  input  logic                        out_ready,
  output logic                        out_valid,
  output bba_pkg::out_item_t          out_data,
  input  bba_pkg::cmd_t               cmd,
  output bba_pkg::sts_t               sts
);
  import bba_pkg::*;

  localparam int MAP_BYTES = (MAX_BLOCKS + BYTE_BITS - 1) / BYTE_BITS;
  localparam int AW        = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int MODC_W    = $clog2(POS_W);

  // Configuration and persistent state.
  logic [CNT_W-1:0] cfg_r, cfg_nxt;
  logic [CNT_W-1:0] hint_r, hint_nxt;

  // Latched operation and pending result.
  logic [MODE_W-1:0] op_mode_r, op_mode_nxt;
  logic [IDX_W-1:0]  op_idx_r, op_idx_nxt;
  out_item_t         res_r, res_nxt;

  // Clear sweep, ring modulo and scan.
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [POS_W-1:0]  dvd_r, dvd_nxt;
  logic [TOT_W-1:0]  rem_r, rem_nxt;
  logic [MODC_W-1:0] mod_cnt_r, mod_cnt_nxt;
  logic [POS_W-1:0]  scan_pos_r, scan_pos_nxt;
  logic [TOT_W-1:0]  issued_r, issued_nxt;
  logic [POS_W-1:0]  chk_pos_r, chk_pos_nxt;
  logic [TOT_W-1:0]  chk_cnt_r, chk_cnt_nxt;
  logic              chk_vld_r, chk_vld_nxt;

  // Output register.
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic [CNT_W-1:0] n_w;
  logic [CNT_W:0]   n_up_w;
  logic [TOT_W-1:0] total_w;
  logic [POS_W-1:0] hint_pos_w;
  logic             in_range_w;
  logic             dec_access_w, dec_find_w, map_none_w;
  logic             issue_w;
  logic [7:0]       ram_rd_data;
  logic             ram_rd_en, ram_wr_en;
  logic [AW-1:0]    ram_rd_addr, ram_wr_addr;
  logic [7:0]       ram_wr_data;
  logic [7:0]       bit_mask_w, lim_mask_w, avail_w;
  logic [2:0]       bit_sel_w;
  logic [CNT_W-1:0] cand_w;
  logic             chk_last_w, hit_w, miss_w, clr_last_w, mod_last_w;
  logic [TOT_W:0]   mod_sh_w;
  logic [TOT_W-1:0] mod_rem_w;
  logic             is_mark_w;
  logic             out_free_w;

  // Effective block count saturates at the map capacity.
  assign n_w        = (32'(cfg_r) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : cfg_r;
  assign n_up_w     = {1'b0, n_w} + (CNT_W + 1)'(7);
  assign total_w    = n_up_w[CNT_W:3];
  assign hint_pos_w = hint_r[CNT_W-1:3];
  assign map_none_w = (total_w == '0);
  assign in_range_w = ({1'b0, in_data.block_index} < n_w);

  assign dec_find_w   = (in_data.mode == MODE_FIND);
  assign dec_access_w = in_range_w && ((in_data.mode == MODE_QUERY) ||
                                       (in_data.mode == MODE_MARK_USED) ||
                                       (in_data.mode == MODE_MARK_FREE));

  assign out_free_w = !out_valid_r || out_ready;

  // Restoring remainder step: one quotient bit per cycle.
  assign mod_sh_w   = {rem_r, dvd_r[POS_W-1]};
  assign mod_rem_w  = (mod_sh_w >= {1'b0, total_w}) ? TOT_W'(mod_sh_w - {1'b0, total_w})
                                                    : mod_sh_w[TOT_W-1:0];
  assign mod_last_w = (mod_cnt_r == MODC_W'(POS_W - 1));

  assign clr_last_w = (clr_cnt_r == AW'(MAP_BYTES - 1));

  // Scan issues one byte read per cycle and checks the byte read the cycle before.
  // The search fails once every byte of the ring has been checked, wherever it started.
  assign issue_w    = cmd.scan_run && (issued_r != total_w);
  assign chk_last_w = ({1'b0, chk_pos_r} == (total_w - TOT_W'(1)));
  assign lim_mask_w = (chk_last_w && (n_w[2:0] != 3'd0)) ? ~(BYTE_FULL << n_w[2:0]) : BYTE_FULL;
  assign avail_w    = ~ram_rd_data & lim_mask_w;
  assign hit_w      = cmd.scan_run && chk_vld_r && (avail_w != 8'h00);
  assign miss_w     = cmd.scan_run && chk_vld_r && !hit_w &&
                      (chk_cnt_r == (total_w - TOT_W'(1)));

  always_comb begin
    bit_sel_w = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (avail_w[i]) bit_sel_w = 3'(i);
    end
  end

  assign cand_w = {chk_pos_r, bit_sel_w};

  assign is_mark_w  = (op_mode_r == MODE_MARK_USED) || (op_mode_r == MODE_MARK_FREE);
  assign bit_mask_w = 8'h01 << op_idx_r[2:0];

  // Map RAM ports.
  assign ram_rd_en   = (cmd.take && dec_access_w) || issue_w;
  assign ram_rd_addr = cmd.take ? AW'(in_data.block_index[IDX_W-1:3]) : AW'(scan_pos_r);
  assign ram_wr_en   = cmd.clr_run || (cmd.access && is_mark_w);
  assign ram_wr_addr = cmd.clr_run ? clr_cnt_r : AW'(op_idx_r[IDX_W-1:3]);
  assign ram_wr_data = cmd.clr_run ? 8'h00 :
                       (op_mode_r == MODE_MARK_USED) ? (ram_rd_data | bit_mask_w)
                                                     : (ram_rd_data & ~bit_mask_w);

  bba_ram #(
    .WIDTH (8),
    .DEPTH (MAP_BYTES)
  ) u_map (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    cfg_nxt       = cfg_r;
    hint_nxt      = hint_r;
    op_mode_nxt   = op_mode_r;
    op_idx_nxt    = op_idx_r;
    res_nxt       = res_r;
    clr_cnt_nxt   = clr_cnt_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    mod_cnt_nxt   = mod_cnt_r;
    scan_pos_nxt  = scan_pos_r;
    issued_nxt    = issued_r;
    chk_pos_nxt   = chk_pos_r;
    chk_cnt_nxt   = chk_cnt_r;
    chk_vld_nxt   = chk_vld_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cfg_valid) cfg_nxt = cfg_data;

    if (cmd.take) begin
      op_mode_nxt = in_data.mode;
      op_idx_nxt  = in_data.block_index;
      res_nxt     = '0;
      if (((in_data.mode == MODE_QUERY) || (in_data.mode == MODE_MARK_USED) ||
           (in_data.mode == MODE_MARK_FREE)) && !in_range_w) begin
        res_nxt.status = STAT_RANGE;
      end else if (dec_find_w && map_none_w) begin
        res_nxt.status = STAT_EXHAUSTED;
      end
      dvd_nxt      = hint_pos_w;
      rem_nxt      = '0;
      mod_cnt_nxt  = '0;
      scan_pos_nxt = hint_pos_w;
      issued_nxt   = '0;
      chk_cnt_nxt  = '0;
      chk_vld_nxt  = 1'b0;
    end

    if (cmd.access && (op_mode_r == MODE_QUERY)) begin
      res_nxt.block_used = |(ram_rd_data & bit_mask_w);
    end

    if (cmd.clr_run) begin
      clr_cnt_nxt = clr_last_w ? '0 : clr_cnt_r + AW'(1);
    end

    if (cmd.mod_run) begin
      rem_nxt     = mod_rem_w;
      dvd_nxt     = {dvd_r[POS_W-2:0], 1'b0};
      mod_cnt_nxt = mod_cnt_r + MODC_W'(1);
      if (mod_last_w) scan_pos_nxt = mod_rem_w[POS_W-1:0];
    end

    if (cmd.scan_run) begin
      chk_vld_nxt = issue_w;
      if (issue_w) begin
        chk_pos_nxt  = scan_pos_r;
        issued_nxt   = issued_r + TOT_W'(1);
        scan_pos_nxt = ({1'b0, scan_pos_r} == (total_w - TOT_W'(1))) ? '0
                                                                      : scan_pos_r + POS_W'(1);
      end
      if (chk_vld_r) chk_cnt_nxt = chk_cnt_r + TOT_W'(1);
      if (hit_w) begin
        res_nxt.found_block = cand_w[IDX_W-1:0];
        hint_nxt            = cand_w + CNT_W'(1);
      end else if (miss_w) begin
        res_nxt.status = STAT_EXHAUSTED;
      end
    end

    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= BLOCK_COUNT_RST;
      hint_r      <= '0;
      clr_cnt_r   <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      hint_r      <= hint_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_mode_r  <= op_mode_nxt;
    op_idx_r   <= op_idx_nxt;
    res_r      <= res_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    mod_cnt_r  <= mod_cnt_nxt;
    scan_pos_r <= scan_pos_nxt;
    issued_r   <= issued_nxt;
    chk_pos_r  <= chk_pos_nxt;
    chk_cnt_r  <= chk_cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    sts            = '0;
    sts.dec_access = dec_access_w;
    sts.dec_clear  = (in_data.mode == MODE_CLEAR);
    sts.dec_find   = dec_find_w;
    sts.map_none   = map_none_w;
    sts.need_mod   = ({1'b0, hint_pos_w} >= total_w);
    sts.clr_last   = clr_last_w;
    sts.mod_last   = mod_last_w;
    sts.scan_hit   = hit_w;
    sts.scan_miss  = miss_w;
    sts.out_free   = out_free_w;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `BBA_ASSERT_IMP(a_found_in_range, hit_w, cand_w < n_w)
  `BBA_ASSERT_IMP(a_no_write_in_scan, cmd.scan_run, !ram_wr_en)
  `BBA_ASSERT_IMP(a_emit_when_free, cmd.emit, out_free_w)

endmodule

@@ design/block_bitmap_allocator_core.sv @@
// Block bitmap allocator: one used bit per block with a next-fit free-block search.
// Channels: input items (mode, block_index) on in_valid/in_ready, one result per item
// (block_used, found_block, status) on out_valid/out_ready, and a write-only block_count
// register on cfg_valid/cfg_ready, which is always ready; the user must see that it is
// written only while idle, as the block itself does not enforce this. One item is worked
// on at a time. A query or mark is a transfer in, one map RAM read, the result register,
// then the output register. An out-of-range index, an unused mode or a find with a zero
// block count skips the map and goes straight to the result register. Find reads one map
// byte per cycle through the RAM read port, from the hint around the ring, until a free
// bit turns up or every byte has been passed over; when the hint lies beyond the current
// ring, a ring remainder step runs first. Clear all writes one map byte per cycle. After
// reset the map's ceil(MAX_BLOCKS/8) bytes (512 by default) are swept to zero with in_ready
// low; the hint resets to zero and block_count to 4096. The output register lets the next
// item be taken while a result waits; when the receiver stalls, the finished result of
// that next item waits in the result register until the output register is free, and no
// further item is taken.
module block_bitmap_allocator_core #(
  parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [bba_pkg::CNT_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  bba_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output bba_pkg::out_item_t        out_data
);
  import bba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  bba_dpath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
